// File: hw/rtl/dq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared widths, operation and status codes, and the pipeline stage record.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int DQ_DEPTH = 16;

    localparam int ACT_W  = 3;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 5;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_BACK  = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_PEEK_FRONT = 3'd4
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Response information waiting for the memory read data
    typedef struct packed {
        logic             valid;
        logic             rd;
        t_status          status;
        logic [CNT_W-1:0] count;
    } t_dq_stage;

endpackage

// File: hw/rtl/dq_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue channels
// Valid/ready request and response channels with source and sink modports.
// ----------------------------------------------------------------------------
interface dq_req_if import dq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [ACT_W-1:0]         action;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface dq_rsp_if import dq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] data;
    logic [STAT_W-1:0]        status;
    logic [CNT_W-1:0]         count;

    modport source (output valid, output data, output status, output count, input ready);
    modport sink   (input valid, input data, input status, input count, output ready);
endinterface

// File: hw/rtl/dq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write the entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read the entry; hold the data between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/dq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue control
// Decodes a request, moves the front pointer and fill count, drives the
// entry memory and holds the response information until the output register
// takes it.
module dq_ctrl import dq_pkg::*; #(
    parameter int DEPTH = DQ_DEPTH,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dq_req_if.sink            i_req,
    input  logic              i_s1_advance,
    output t_dq_stage         o_s1,
    output logic              o_mem_we,
    output logic [AW-1:0]     o_mem_waddr,
    output logic [DATA_W-1:0] o_mem_wdata,
    output logic              o_mem_re,
    output logic [AW-1:0]     o_mem_raddr
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_P = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_OFF = AW'(DEPTH - 1);

    logic [AW-1:0]  r_front, n_front;
    logic [CW-1:0]  r_count, n_count;
    t_dq_stage      r_s1;

    logic                w_fire;
    logic                w_full;
    logic                w_empty;
    logic [CW-1:0]       w_count_dec;
    logic                w_we;
    logic                w_re;
    logic [AW-1:0]       w_waddr;
    logic [AW-1:0]       w_raddr;
    logic                w_rd;
    t_status             w_status;
    logic [CW+CNT_W-1:0] w_count_ext;

    // Wrap front pointer plus offset into the circular store
    function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] front,
                                              input logic [AW-1:0] offset);
        logic [AW:0] pos;
        pos = {1'b0, front} + {1'b0, offset};
        if (pos >= DEPTH_P) begin
            pos = pos - DEPTH_P;
        end
        return pos[AW-1:0];
    endfunction

    assign i_req.ready = !r_s1.valid || i_s1_advance;
    assign w_fire      = i_req.valid && i_req.ready;
    assign w_full      = (r_count == DEPTH_C);
    assign w_empty     = (r_count == '0);
    assign w_count_dec = r_count - CW'(1);

    // Decode the operation
    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        w_we     = 1'b0;
        w_re     = 1'b0;
        w_waddr  = slot_at(r_front, r_count[AW-1:0]);
        w_raddr  = r_front;
        w_rd     = 1'b0;
        w_status = ST_OK;
        unique case (t_action'(i_req.action))
            ACT_PUSH_BACK: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_we    = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            ACT_PUSH_FRONT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    n_front = slot_at(r_front, LAST_OFF);
                    w_waddr = n_front;
                    w_we    = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            ACT_POP_FRONT: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_re    = 1'b1;
                    w_rd    = 1'b1;
                    n_front = slot_at(r_front, AW'(1));
                    n_count = w_count_dec;
                end
            end
            ACT_POP_BACK: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_re    = 1'b1;
                    w_rd    = 1'b1;
                    w_raddr = slot_at(r_front, w_count_dec[AW-1:0]);
                    n_count = w_count_dec;
                end
            end
            ACT_PEEK_FRONT: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_re = 1'b1;
                    w_rd = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Report the count modulo the field width
    assign w_count_ext = {{CNT_W{1'b0}}, n_count};

    assign o_mem_we    = w_fire && w_we;
    assign o_mem_waddr = w_waddr;
    assign o_mem_wdata = i_req.value;
    assign o_mem_re    = w_fire && w_re;
    assign o_mem_raddr = w_raddr;

    // Advance pointers and hold the response information
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_s1    <= '0;
        end else begin
            if (w_fire) begin
                r_front      <= n_front;
                r_count      <= n_count;
                r_s1.valid   <= 1'b1;
                r_s1.rd      <= w_rd;
                r_s1.status  <= w_status;
                r_s1.count   <= w_count_ext[CNT_W-1:0];
            end else if (i_s1_advance) begin
                r_s1.valid <= 1'b0;
            end
        end
    end

    assign o_s1 = r_s1;

endmodule

// File: hw/rtl/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of signed 32-bit words in a circular single-port-pair RAM.
// ----------------------------------------------------------------------------
// The block takes one request per cycle while the read stage can advance
// (push back, push front, pop front, pop back, peek front) and returns
// exactly one response per request, after the registered read of the
// entry RAM and the output register. Pointer and fill count live in
// registers and are updated at acceptance, so back-to-back requests need no
// interlock; each request touches at most one RAM entry. The response holds
// the popped or peeked word (zero otherwise), a status (ok, empty, full) and
// the fill after the request, modulo 32. A push to a full queue is dropped.
// No clearing pass is needed after reset.
module double_ended_queue import dq_pkg::*; #(
    parameter int DEPTH = DQ_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dq_req_if.sink   i_req,
    dq_rsp_if.source o_rsp
);

    localparam int AW = $clog2(DEPTH);

    t_dq_stage          w_s1;
    logic               w_s1_advance;
    logic               w_mem_we;
    logic [AW-1:0]      w_mem_waddr;
    logic [DATA_W-1:0]  w_mem_wdata;
    logic               w_mem_re;
    logic [AW-1:0]      w_mem_raddr;
    logic [DATA_W-1:0]  w_mem_rdata;

    logic               r_out_valid;
    logic [DATA_W-1:0]  r_out_data;
    t_status            r_out_status;
    logic [CNT_W-1:0]   r_out_count;

    assign w_s1_advance = w_s1.valid && (!r_out_valid || o_rsp.ready);

    dq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_s1_advance (w_s1_advance),
        .o_s1         (w_s1),
        .o_mem_we     (w_mem_we),
        .o_mem_waddr  (w_mem_waddr),
        .o_mem_wdata  (w_mem_wdata),
        .o_mem_re     (w_mem_re),
        .o_mem_raddr  (w_mem_raddr)
    );

    dq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // Load the response register; drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_out_data   <= '0;
            r_out_status <= ST_OK;
            r_out_count  <= '0;
        end else begin
            if (w_s1_advance) begin
                r_out_valid  <= 1'b1;
                r_out_data   <= w_s1.rd ? w_mem_rdata : '0;
                r_out_status <= w_s1.status;
                r_out_count  <= w_s1.count;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.data   = r_out_data;
    assign o_rsp.status = r_out_status;
    assign o_rsp.count  = r_out_count;

    // A full report always shows a full queue
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.status == ST_FULL) |-> o_rsp.count == CNT_W'(DEPTH))
        else $error("full response with count not at depth");

    // An empty report shows no words and no data
    a_empty_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.status == ST_EMPTY) |-> (o_rsp.count == '0) && (o_rsp.data == '0))
        else $error("empty response with words or data");

    // Every accepted request enters the read stage
    a_req_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> w_s1.valid)
        else $error("accepted request lost before read stage");

    // A read word only comes with an ok status
    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.data != '0) |-> o_rsp.status == ST_OK)
        else $error("data returned with error status");

endmodule
